[rtl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Operation codes, result kinds, engine states and the status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

	localparam int HANDLE_W    = 4;
	localparam int NUM_HANDLES = 16;
	localparam int PORT_TIME_W = 32;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_ADJUST = 2'd1,
		OP_DELETE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_OK       = 3'd0,
		K_FULL     = 3'd1,
		K_INACTIVE = 3'd2,
		K_DUP      = 3'd3,
		K_EXPIRED  = 3'd4,
		K_NONE     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_FIND = 2'd1,
		ST_SEEK = 2'd2,
		ST_TICK = 2'd3
	} state_t;

	// Engine status seen by the top level checks.
	typedef struct packed {
		logic                   busy;
		logic [NUM_HANDLES-1:0] active;
	} stq_status_t;

endpackage

`default_nettype wire

[rtl/sorted_timer_queue_unit.sv]
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit: sorted timer list with add, adjust, delete, tick
// Keeps up to DEPTH timers ordered by expiry and reports expired timers.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH timers sorted by ascending expiry, earlier
// inserts first among equal expiries. Requests enter a two-entry queue and
// are carried out one at a time by an engine that walks the table one entry
// per cycle. Every request gives one result beat except a tick, which gives
// one beat per expired timer with last_of_run on the final one, or a single
// K_NONE beat when no timer has expired. A new request is queued while a
// result waits to be taken.

`default_nettype none

module sorted_timer_queue_unit import stq_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             opcode,
	input  wire logic [HANDLE_W-1:0]    timer_id,
	input  wire logic [PORT_TIME_W-1:0] expire_time,
	input  wire logic [PORT_TIME_W-1:0] current_time,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [2:0]                  result_kind,
	output logic [HANDLE_W-1:0]         expired_id,
	output logic [PORT_TIME_W-1:0]      expired_at,
	output logic                        last_of_run
);

	logic                         q_valid;
	logic                         q_pop;
	op_t                          q_op;
	logic [HANDLE_W-1:0]          q_id;
	logic [TIME_BITS-1:0]         q_et;
	logic [TIME_BITS-1:0]         q_now;
	stq_status_t                  status;
	logic [$clog2(DEPTH+1)-1:0]   count;

	stq_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.timer_id     (timer_id),
		.expire_time  (expire_time),
		.current_time (current_time),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_op         (q_op),
		.q_id         (q_id),
		.q_et         (q_et),
		.q_now        (q_now)
	);

	stq_back #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_op        (q_op),
		.q_id        (q_id),
		.q_et        (q_et),
		.q_now       (q_now),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.expired_id  (expired_id),
		.expired_at  (expired_at),
		.last_of_run (last_of_run),
		.status      (status),
		.count       (count)
	);

	// Between requests every active handle owns exactly one table entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		!status.busy |-> $countones(status.active) == int'(count))
		else $error("active handles and table fill disagree");

	// The table never holds more than DEPTH entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(count) <= DEPTH)
		else $error("table fill beyond depth");

	// The engine only takes a request from the queue when one is there.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && !status.busy)
		else $error("request taken from empty queue or while busy");

endmodule

`default_nettype wire

[rtl/stq_front.sv]
// ----------------------------------------------------------------------------
// stq_front: input side of the sorted timer queue
// Takes request beats, decodes the opcode, fits times to the internal width
// and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_front import stq_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             opcode,
	input  wire logic [HANDLE_W-1:0]    timer_id,
	input  wire logic [PORT_TIME_W-1:0] expire_time,
	input  wire logic [PORT_TIME_W-1:0] current_time,
	output logic                        q_valid,
	input  wire logic                   q_pop,
	output op_t                         q_op,
	output logic [HANDLE_W-1:0]         q_id,
	output logic [TIME_BITS-1:0]        q_et,
	output logic [TIME_BITS-1:0]        q_now
);

	logic [TIME_BITS+PORT_TIME_W-1:0] et_wide;
	logic [TIME_BITS+PORT_TIME_W-1:0] now_wide;
	logic                             push;
	logic                             wr_ptr_q;
	logic                             rd_ptr_q;
	logic [1:0]                       fill_q;
	op_t                              op_mem [2];
	logic [HANDLE_W-1:0]              id_mem [2];
	logic [TIME_BITS-1:0]             et_mem [2];
	logic [TIME_BITS-1:0]             now_mem [2];

	// Times are taken modulo 2^TIME_BITS.
	assign et_wide  = {{TIME_BITS{1'b0}}, expire_time};
	assign now_wide = {{TIME_BITS{1'b0}}, current_time};

	assign in_stall = fill_q[1];
	assign push     = in_valid && !fill_q[1];
	assign q_valid  = fill_q != 2'd0;

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !q_pop)
				fill_q <= fill_q + 2'd1;
			else if (!push && q_pop)
				fill_q <= fill_q - 2'd1;
		end
	end

	// Queue storage; the opcode is decoded on the way in.
	always_ff @(posedge clk) begin
		if (push) begin
			op_mem[wr_ptr_q]  <= op_t'(opcode);
			id_mem[wr_ptr_q]  <= timer_id;
			et_mem[wr_ptr_q]  <= et_wide[TIME_BITS-1:0];
			now_mem[wr_ptr_q] <= now_wide[TIME_BITS-1:0];
		end
	end

	assign q_op  = op_mem[rd_ptr_q];
	assign q_id  = id_mem[rd_ptr_q];
	assign q_et  = et_mem[rd_ptr_q];
	assign q_now = now_mem[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/stq_back.sv]
// ----------------------------------------------------------------------------
// stq_back: timer table engine of the sorted timer queue
// Holds the sorted table, walks it one entry per cycle for searches and
// drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_back import stq_pkg::*; #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	output logic                             q_pop,
	input  wire op_t                         q_op,
	input  wire logic [HANDLE_W-1:0]         q_id,
	input  wire logic [TIME_BITS-1:0]        q_et,
	input  wire logic [TIME_BITS-1:0]        q_now,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [2:0]                       result_kind,
	output logic [HANDLE_W-1:0]              expired_id,
	output logic [PORT_TIME_W-1:0]           expired_at,
	output logic                             last_of_run,
	output stq_status_t                      status,
	output logic [$clog2(DEPTH+1)-1:0]       count
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	state_t                 state_q, state_d;
	op_t                    op_q;
	logic [HANDLE_W-1:0]    id_q;
	logic [TIME_BITS-1:0]   et_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [CNT_W-1:0]       idx_q, idx_d;
	logic [CNT_W-1:0]       cnt_q;
	logic [NUM_HANDLES-1:0] act_q;
	logic [TIME_BITS-1:0]   exp_q [DEPTH];
	logic [HANDLE_W-1:0]    hdl_q [DEPTH];

	logic                   ov_q;
	kind_t                  okind_q;
	logic [HANDLE_W-1:0]    oid_q;
	logic [TIME_BITS-1:0]   oat_q;
	logic                   olast_q;

	logic                   out_free;
	logic [TIME_BITS-1:0]   cur_e;
	logic [HANDLE_W-1:0]    cur_h;
	logic                   idx_lt;
	logic                   head_hit;
	logic                   second_hit;
	logic                   ld;
	logic                   emit;
	kind_t                  e_kind;
	logic [HANDLE_W-1:0]    e_id;
	logic [TIME_BITS-1:0]   e_at;
	logic                   e_last;
	logic                   ins;
	logic                   rem;
	logic [IDX_W-1:0]       pos;
	logic                   act_set;
	logic                   act_clr;
	logic [HANDLE_W-1:0]    act_h;
	logic [TIME_BITS+PORT_TIME_W-1:0] oat_wide;

	assign out_free   = !ov_q || !out_stall;
	assign cur_e      = exp_q[idx_q[IDX_W-1:0]];
	assign cur_h      = hdl_q[idx_q[IDX_W-1:0]];
	assign idx_lt     = idx_q < cnt_q;
	assign head_hit   = (cnt_q != '0) && (exp_q[0] <= now_q);
	assign second_hit = (cnt_q > CNT_W'(1)) && (exp_q[1] <= now_q);

	// Next state and control for the table walk.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		ld      = 1'b0;
		emit    = 1'b0;
		e_kind  = K_OK;
		e_id    = id_q;
		e_at    = '0;
		e_last  = 1'b1;
		ins     = 1'b0;
		rem     = 1'b0;
		pos     = idx_q[IDX_W-1:0];
		idx_d   = idx_q;
		act_set = 1'b0;
		act_clr = 1'b0;
		act_h   = id_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					ld    = 1'b1;
					idx_d = '0;
					e_id  = q_id;
					unique case (q_op)
						OP_ADD: begin
							if (act_q[q_id])
								state_d = ST_FIND;
							else if (cnt_q == CNT_W'(DEPTH)) begin
								emit   = 1'b1;
								e_kind = K_FULL;
								e_at   = q_et;
							end else
								state_d = ST_SEEK;
						end
						OP_ADJUST, OP_DELETE: begin
							if (act_q[q_id])
								state_d = ST_FIND;
							else begin
								emit   = 1'b1;
								e_kind = K_INACTIVE;
							end
						end
						default: state_d = ST_TICK;
					endcase
				end
			end
			ST_FIND: begin
				if (!idx_lt) begin
					if (out_free) begin
						emit    = 1'b1;
						e_kind  = K_INACTIVE;
						state_d = ST_IDLE;
					end
				end else if (cur_h == id_q) begin
					unique case (op_q)
						OP_ADD: begin
							if (out_free) begin
								emit    = 1'b1;
								e_kind  = K_DUP;
								e_at    = cur_e;
								state_d = ST_IDLE;
							end
						end
						OP_ADJUST: begin
							rem     = 1'b1;
							idx_d   = '0;
							state_d = ST_SEEK;
						end
						OP_DELETE: begin
							if (out_free) begin
								emit    = 1'b1;
								e_at    = cur_e;
								rem     = 1'b1;
								act_clr = 1'b1;
								state_d = ST_IDLE;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end else
					idx_d = idx_q + CNT_W'(1);
			end
			ST_SEEK: begin
				if (idx_lt && (cur_e <= et_q))
					idx_d = idx_q + CNT_W'(1);
				else if (out_free) begin
					ins     = 1'b1;
					act_set = 1'b1;
					emit    = 1'b1;
					e_at    = et_q;
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (out_free) begin
					emit = 1'b1;
					if (head_hit) begin
						e_kind  = K_EXPIRED;
						e_id    = hdl_q[0];
						e_at    = exp_q[0];
						e_last  = !second_hit;
						rem     = 1'b1;
						pos     = '0;
						act_clr = 1'b1;
						act_h   = hdl_q[0];
						if (!second_hit)
							state_d = ST_IDLE;
					end else begin
						e_kind  = K_NONE;
						e_id    = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			act_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (ins)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (rem)
				cnt_q <= cnt_q - CNT_W'(1);
			if (act_set)
				act_q[act_h] <= 1'b1;
			else if (act_clr)
				act_q[act_h] <= 1'b0;
			if (emit)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	// Latched request and result beat.
	always_ff @(posedge clk) begin
		if (ld) begin
			op_q  <= q_op;
			id_q  <= q_id;
			et_q  <= q_et;
			now_q <= q_now;
		end
		if (emit) begin
			okind_q <= e_kind;
			oid_q   <= e_id;
			oat_q   <= e_at;
			olast_q <= e_last;
		end
	end

	// Sorted table: removal closes the gap, insertion opens one.
	always_ff @(posedge clk) begin
		if (rem) begin
			for (int i = 0; i < DEPTH-1; i++) begin
				if (i >= int'(pos)) begin
					exp_q[i] <= exp_q[i+1];
					hdl_q[i] <= hdl_q[i+1];
				end
			end
		end
		if (ins) begin
			for (int i = 1; i < DEPTH; i++) begin
				if (i > int'(pos)) begin
					exp_q[i] <= exp_q[i-1];
					hdl_q[i] <= hdl_q[i-1];
				end
			end
			exp_q[pos] <= et_q;
			hdl_q[pos] <= id_q;
		end
	end

	assign oat_wide    = {{PORT_TIME_W{1'b0}}, oat_q};
	assign out_valid   = ov_q;
	assign result_kind = okind_q;
	assign expired_id  = oid_q;
	assign expired_at  = oat_wide[PORT_TIME_W-1:0];
	assign last_of_run = olast_q;
	assign status      = '{busy: state_q != ST_IDLE, active: act_q};
	assign count       = cnt_q;

endmodule

`default_nettype wire
